>>> design/scp_pkg.sv
package scp_pkg;

  localparam int LINE_BYTES  = 6;
  localparam int STORE_DEPTH = LINE_BYTES - 1;
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int BYTE_W      = 8;
  localparam int DATA_W      = 14;
  localparam int VAL_W       = DATA_W + 1;
  localparam int ACC_W       = VAL_W + 4;
  localparam int CFG_IDX_W   = 2;

  localparam logic [VAL_W-1:0] VAL_SAT = {1'b1, {DATA_W{1'b0}}};

  localparam logic [BYTE_W-1:0] CHR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHR_HT    = 8'h09;
  localparam logic [BYTE_W-1:0] CHR_FF    = 8'h0C;
  localparam logic [BYTE_W-1:0] CHR_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CHR_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CHR_0     = 8'h30;
  localparam logic [BYTE_W-1:0] CHR_9     = 8'h39;
  localparam logic [BYTE_W-1:0] CHR_O     = 8'h6F;
  localparam logic [BYTE_W-1:0] CHR_N     = 8'h6E;
  localparam logic [BYTE_W-1:0] CHR_F_LC  = 8'h66;
  localparam logic [BYTE_W-1:0] CHR_T     = 8'h54;
  localparam logic [BYTE_W-1:0] CHR_F     = 8'h46;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE  = 2'd2;

  localparam logic [DATA_W-1:0] RST_MIN_PERIOD = 14'd10;
  localparam logic [DATA_W-1:0] RST_MAX_PERIOD = 14'd5000;
  localparam logic [DATA_W-1:0] RST_MIN_PULSE  = 14'd0;
  localparam logic [DATA_W-1:0] RST_PERIOD     = 14'd10;
  localparam logic [DATA_W-1:0] RST_PULSE      = 14'd0;

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_ON     = 3'd1,
    KIND_OFF    = 3'd2,
    KIND_PERIOD = 3'd3,
    KIND_PULSE  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CLAMP_LO,
    ST_CLAMP_HI,
    ST_ECHO
  } state_t;

  typedef struct packed {
    logic load_byte;
    logic start_line;
    logic dec_step;
    logic clamp_lo;
    logic clamp_hi;
    logic echo_next;
  } ctl_t;

  typedef struct packed {
    logic rx_is_cr;
    logic needs_num;
    logic dec_done;
    logic echo_last;
  } sts_t;

endpackage

>>> design/scp_if.sv
interface scp_rx_if;
  logic                          valid;
  logic                          ready;
  logic [scp_pkg::BYTE_W-1:0]    rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface scp_tx_if;
  logic                          valid;
  logic                          ready;
  logic [scp_pkg::BYTE_W-1:0]    tx_byte;
  logic                          echo_last;
  logic [2:0]                    command_kind;
  logic                          pwm_enabled;
  logic [scp_pkg::DATA_W-1:0]    period_value;
  logic [scp_pkg::DATA_W-1:0]    pulse_value;

  modport source (output valid, output tx_byte, output echo_last, output command_kind,
                  output pwm_enabled, output period_value, output pulse_value,
                  input ready);
  modport sink   (input valid, input tx_byte, input echo_last, input command_kind,
                  input pwm_enabled, input period_value, input pulse_value,
                  output ready);
endinterface

interface scp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [scp_pkg::CFG_IDX_W-1:0] index;
  logic [scp_pkg::DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/scp_ctrl.sv
module scp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          rx_valid,
  output logic          rx_ready,
  output logic          tx_valid,
  input  logic          tx_ready,
  input  scp_pkg::sts_t sts,
  output scp_pkg::ctl_t ctl
);

  scp_pkg::state_t state;
  scp_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    rx_ready   = 1'b0;
    tx_valid   = 1'b0;
    case (state)
      scp_pkg::ST_IDLE: begin
        rx_ready = 1'b1;
        if (rx_valid) begin
          if (sts.rx_is_cr) begin
            ctl.start_line = 1'b1;
            state_next     = sts.needs_num ? scp_pkg::ST_DECODE : scp_pkg::ST_ECHO;
          end else begin
            ctl.load_byte = 1'b1;
          end
        end
      end
      scp_pkg::ST_DECODE: begin
        if (sts.dec_done) begin
          state_next = scp_pkg::ST_CLAMP_LO;
        end else begin
          ctl.dec_step = 1'b1;
        end
      end
      scp_pkg::ST_CLAMP_LO: begin
        ctl.clamp_lo = 1'b1;
        state_next   = scp_pkg::ST_CLAMP_HI;
      end
      scp_pkg::ST_CLAMP_HI: begin
        ctl.clamp_hi = 1'b1;
        state_next   = scp_pkg::ST_ECHO;
      end
      scp_pkg::ST_ECHO: begin
        tx_valid = 1'b1;
        if (tx_ready) begin
          ctl.echo_next = 1'b1;
          if (sts.echo_last) begin
            state_next = scp_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = scp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> design/scp_dpath.sv
module scp_dpath (
  input  logic                             clk,
  input  logic                             rst,
  input  scp_pkg::ctl_t                    ctl,
  output scp_pkg::sts_t                    sts,
  input  logic [scp_pkg::BYTE_W-1:0]       rx_byte,
  input  logic                             cfg_we,
  input  logic [scp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [scp_pkg::DATA_W-1:0]       cfg_data,
  output logic [scp_pkg::BYTE_W-1:0]       tx_byte,
  output logic                             echo_last,
  output logic [2:0]                       command_kind,
  output logic                             pwm_enabled,
  output logic [scp_pkg::DATA_W-1:0]       period_value,
  output logic [scp_pkg::DATA_W-1:0]       pulse_value
);

  logic [scp_pkg::BYTE_W-1:0] store [scp_pkg::STORE_DEPTH];
  logic [scp_pkg::CNT_W-1:0]  cnt;
  logic [scp_pkg::CNT_W-1:0]  ptr;
  logic                       phase_dig;
  logic                       neg;
  logic [scp_pkg::VAL_W-1:0]  val;
  scp_pkg::kind_t             kind;
  logic                       enable;
  logic [scp_pkg::DATA_W-1:0] period;
  logic [scp_pkg::DATA_W-1:0] pulse;
  logic [scp_pkg::DATA_W-1:0] min_period;
  logic [scp_pkg::DATA_W-1:0] max_period;
  logic [scp_pkg::DATA_W-1:0] min_pulse;

  logic                       in_range;
  logic [scp_pkg::BYTE_W-1:0] cur;
  logic                       is_ws;
  logic                       is_sign;
  logic                       is_digit;
  logic                       is_on;
  logic                       is_off;
  logic                       is_t;
  logic                       is_f;
  scp_pkg::kind_t             line_kind;
  logic [scp_pkg::ACC_W-1:0]  acc;
  logic [scp_pkg::VAL_W-1:0]  acc_sat;
  logic                       below_zero;
  logic [scp_pkg::VAL_W-1:0]  lo_val;
  logic [scp_pkg::VAL_W-1:0]  hi_lim;
  logic [scp_pkg::VAL_W-1:0]  hi_val;

  assign in_range = ptr < cnt;
  assign cur      = in_range ? store[ptr[scp_pkg::IDX_W-1:0]] : '0;

  always_comb begin
    is_ws    = cur inside {scp_pkg::CHR_SPACE, [scp_pkg::CHR_HT:scp_pkg::CHR_FF]};
    is_sign  = cur inside {scp_pkg::CHR_PLUS, scp_pkg::CHR_MINUS};
    is_digit = cur inside {[scp_pkg::CHR_0:scp_pkg::CHR_9]};
  end

  // fixed taps at the head of the line
  always_comb begin
    is_on  = (cnt >= scp_pkg::CNT_W'(2)) && store[0] == scp_pkg::CHR_O &&
             store[1] == scp_pkg::CHR_N;
    is_off = (cnt >= scp_pkg::CNT_W'(3)) && store[0] == scp_pkg::CHR_O &&
             store[1] == scp_pkg::CHR_F_LC && store[2] == scp_pkg::CHR_F_LC;
    is_t   = (cnt >= scp_pkg::CNT_W'(1)) && store[0] == scp_pkg::CHR_T;
    is_f   = (cnt >= scp_pkg::CNT_W'(1)) && store[0] == scp_pkg::CHR_F;
    if (is_on) begin
      line_kind = scp_pkg::KIND_ON;
    end else if (is_off) begin
      line_kind = scp_pkg::KIND_OFF;
    end else if (is_t) begin
      line_kind = scp_pkg::KIND_PERIOD;
    end else if (is_f) begin
      line_kind = scp_pkg::KIND_PULSE;
    end else begin
      line_kind = scp_pkg::KIND_NONE;
    end
  end

  // val * 10 + digit, saturating above the 14-bit range
  always_comb begin
    acc = (scp_pkg::ACC_W'(val) << 3) + (scp_pkg::ACC_W'(val) << 1) +
          scp_pkg::ACC_W'(cur[3:0]);
    acc_sat = (acc > scp_pkg::ACC_W'(scp_pkg::VAL_SAT)) ? scp_pkg::VAL_SAT
                                                        : acc[scp_pkg::VAL_W-1:0];
  end

  always_comb begin
    below_zero = neg && (val != '0);
    if (kind == scp_pkg::KIND_PERIOD) begin
      if (below_zero || val < {1'b0, min_period}) begin
        lo_val = {1'b0, min_period};
      end else begin
        lo_val = val;
      end
      hi_lim = {1'b0, max_period};
    end else begin
      if (below_zero || val < {1'b0, min_pulse}) begin
        lo_val = '0;
      end else begin
        lo_val = val;
      end
      hi_lim = {1'b0, period};
    end
    hi_val = (val > hi_lim) ? hi_lim : val;
  end

  always_comb begin
    sts.rx_is_cr  = rx_byte == scp_pkg::CHR_CR;
    sts.needs_num = is_t || is_f;
    sts.echo_last = ptr == cnt;
    if (!in_range) begin
      sts.dec_done = 1'b1;
    end else if (phase_dig) begin
      sts.dec_done = !is_digit;
    end else begin
      sts.dec_done = !(is_ws || is_sign || is_digit);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_byte && cnt < scp_pkg::CNT_W'(scp_pkg::STORE_DEPTH)) begin
      store[cnt[scp_pkg::IDX_W-1:0]] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start_line) begin
      ptr       <= is_on || is_off || line_kind == scp_pkg::KIND_NONE ? '0
                                                                       : scp_pkg::CNT_W'(1);
      phase_dig <= 1'b0;
      neg       <= 1'b0;
      val       <= '0;
    end else if (ctl.dec_step) begin
      ptr <= ptr + scp_pkg::CNT_W'(1);
      if (phase_dig || is_digit) begin
        phase_dig <= 1'b1;
        val       <= acc_sat;
      end else if (is_sign) begin
        phase_dig <= 1'b1;
        neg       <= cur == scp_pkg::CHR_MINUS;
      end
    end else if (ctl.clamp_lo) begin
      val <= lo_val;
    end else if (ctl.clamp_hi) begin
      ptr <= '0;
    end else if (ctl.echo_next && ptr != cnt) begin
      ptr <= ptr + scp_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      kind   <= scp_pkg::KIND_NONE;
      enable <= 1'b0;
      period <= scp_pkg::RST_PERIOD;
      pulse  <= scp_pkg::RST_PULSE;
    end else begin
      if (ctl.load_byte && cnt < scp_pkg::CNT_W'(scp_pkg::STORE_DEPTH)) begin
        cnt <= cnt + scp_pkg::CNT_W'(1);
      end
      if (ctl.echo_next && ptr == cnt) begin
        cnt <= '0;
      end
      if (ctl.start_line) begin
        kind <= line_kind;
        if (is_on) begin
          enable <= 1'b1;
        end else if (is_off) begin
          enable <= 1'b0;
        end
      end
      if (ctl.clamp_hi) begin
        if (kind == scp_pkg::KIND_PERIOD) begin
          period <= hi_val[scp_pkg::DATA_W-1:0];
        end else begin
          pulse <= hi_val[scp_pkg::DATA_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_period <= scp_pkg::RST_MIN_PERIOD;
      max_period <= scp_pkg::RST_MAX_PERIOD;
      min_pulse  <= scp_pkg::RST_MIN_PULSE;
    end else if (cfg_we) begin
      case (cfg_index)
        scp_pkg::REG_MIN_PERIOD: min_period <= cfg_data;
        scp_pkg::REG_MAX_PERIOD: max_period <= cfg_data;
        scp_pkg::REG_MIN_PULSE:  min_pulse  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign tx_byte      = (ptr == cnt) ? scp_pkg::CHR_CR : cur;
  assign echo_last    = ptr == cnt;
  assign command_kind = kind;
  assign pwm_enabled  = enable;
  assign period_value = period;
  assign pulse_value  = pulse;

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= scp_pkg::CNT_W'(scp_pkg::STORE_DEPTH))
    else $error("line count beyond store depth");

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    ctl.echo_next |-> ptr <= cnt)
    else $error("echo pointer past line end");

  a_line_clear: assert property (@(posedge clk) disable iff (rst)
    ctl.echo_next && ptr == cnt |=> cnt == '0)
    else $error("line not cleared after final echo");

  a_period_max: assert property (@(posedge clk) disable iff (rst)
    ctl.clamp_hi && kind == scp_pkg::KIND_PERIOD |=> period <= max_period)
    else $error("period above upper clamp");

  a_pulse_fit: assert property (@(posedge clk) disable iff (rst)
    ctl.clamp_hi && kind == scp_pkg::KIND_PULSE |=> pulse <= period)
    else $error("pulse wider than period");

endmodule

>>> design/serial_command_line_parser.sv
// Serial command line parser. Received bytes other than CR are kept in a
// line store of LINE_BYTES-1 bytes; bytes past a full store are dropped.
// A CR ends the line: "on"/"off" switch the PWM enable, "T<n>" sets the
// period clamped to [min_period, max_period] (upper clamp wins), "F<n>" sets
// the pulse width (0 below min_pulse, at most the period). The line is then
// echoed one byte per transfer, closed by a CR with echo_last high, and every
// echo carries the settings after the command. A CR starts the handling of
// the line: for T/F lines a decode step per skipped or parsed character up to
// the end of the number, then a lower and an upper clamp step; then one echo
// transfer per stored byte plus one for the closing CR, waiting while the
// receiver stalls. All of it walks the line store through a single shared
// pointer. Input is not taken while a line is being handled.
// Configuration writes are always accepted and should be made while idle.
module serial_command_line_parser (
  input logic       clk,
  input logic       rst,
  scp_rx_if.sink    rx,
  scp_tx_if.source  tx,
  scp_cfg_if.sink   cfg
);

  scp_pkg::ctl_t ctl;
  scp_pkg::sts_t sts;

  assign cfg.ready = 1'b1;

  scp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx.valid),
    .rx_ready (rx.ready),
    .tx_valid (tx.valid),
    .tx_ready (tx.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  scp_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .sts          (sts),
    .rx_byte      (rx.rx_byte),
    .cfg_we       (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .tx_byte      (tx.tx_byte),
    .echo_last    (tx.echo_last),
    .command_kind (tx.command_kind),
    .pwm_enabled  (tx.pwm_enabled),
    .period_value (tx.period_value),
    .pulse_value  (tx.pulse_value)
  );

endmodule

>>> tb/serial_command_line_parser_checker.sv
`timescale 1ns / 100ps

module serial_command_line_parser_checker
  import scp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  scp_rx_if    rx,
  scp_tx_if    tx,
  scp_cfg_if   cfg,
  output int   mismatches,
  output int   pending
);

  typedef struct packed {
    logic [BYTE_W-1:0] tx_byte;
    logic              echo_last;
    kind_t             command_kind;
    logic              pwm_enabled;
    logic [DATA_W-1:0] period_value;
    logic [DATA_W-1:0] pulse_value;
  } echo_t;

  echo_t             echo_queue[$];
  logic [BYTE_W-1:0] line_buf[STORE_DEPTH];
  int unsigned       line_len;
  logic              pwm_on;
  logic [DATA_W-1:0] period_ms;
  logic [DATA_W-1:0] pulse_ms;
  logic [DATA_W-1:0] min_period_cfg;
  logic [DATA_W-1:0] max_period_cfg;
  logic [DATA_W-1:0] min_pulse_cfg;

  function automatic logic char_at(int unsigned pos, logic [BYTE_W-1:0] ch);
    return pos < line_len && line_buf[pos] == ch;
  endfunction

  // value after the command letter: blanks, optional sign, digits
  function automatic int line_number();
    int unsigned p;
    logic        neg;
    int          v;
    p = 1;
    neg = 1'b0;
    v = 0;
    while (p < line_len && (line_buf[p] == CHR_SPACE ||
           (line_buf[p] >= CHR_HT && line_buf[p] <= CHR_FF)))
      p++;
    if (p < line_len && (line_buf[p] == CHR_PLUS || line_buf[p] == CHR_MINUS)) begin
      neg = (line_buf[p] == CHR_MINUS);
      p++;
    end
    while (p < line_len && line_buf[p] >= CHR_0 && line_buf[p] <= CHR_9) begin
      if (v < 100000000)
        v = v * 10 + int'(line_buf[p] - CHR_0);
      p++;
    end
    return neg ? -v : v;
  endfunction

  task automatic predict_line_echo(input logic [BYTE_W-1:0] b);
    kind_t kind;
    int    v;
    echo_t e;
    if (b != CHR_CR) begin
      if (line_len < STORE_DEPTH) begin
        line_buf[line_len] = b;
        line_len++;
      end
      return;
    end
    kind = KIND_NONE;
    if (char_at(0, CHR_O) && char_at(1, CHR_N)) begin
      pwm_on = 1'b1;
      kind = KIND_ON;
    end else if (char_at(0, CHR_O) && char_at(1, CHR_F_LC) && char_at(2, CHR_F_LC)) begin
      pwm_on = 1'b0;
      kind = KIND_OFF;
    end else if (char_at(0, CHR_T)) begin
      v = line_number();
      if (v < int'(min_period_cfg))
        v = int'(min_period_cfg);
      if (v > int'(max_period_cfg))
        v = int'(max_period_cfg);
      period_ms = DATA_W'(v);
      kind = KIND_PERIOD;
    end else if (char_at(0, CHR_F)) begin
      v = line_number();
      if (v < int'(min_pulse_cfg))
        v = 0;
      if (v > int'(period_ms))
        v = int'(period_ms);
      if (v < 0)
        v = 0;
      pulse_ms = DATA_W'(v);
      kind = KIND_PULSE;
    end
    for (int unsigned i = 0; i <= line_len; i++) begin
      e.tx_byte      = (i == line_len) ? CHR_CR : line_buf[i];
      e.echo_last    = (i == line_len);
      e.command_kind = kind;
      e.pwm_enabled  = pwm_on;
      e.period_value = period_ms;
      e.pulse_value  = pulse_ms;
      echo_queue.push_back(e);
    end
    line_len = 0;
  endtask

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic check_echo(input echo_t got);
    echo_t want;
    if (echo_queue.size() == 0) begin
      $display("%0t: echo transfer with nothing expected, expected none got tx_byte %h",
               $time, got.tx_byte);
      mismatches++;
      return;
    end
    want = echo_queue.pop_front();
    compare_field("tx_byte", want.tx_byte, got.tx_byte);
    compare_field("echo_last", want.echo_last, got.echo_last);
    compare_field("command_kind", want.command_kind, got.command_kind);
    compare_field("pwm_enabled", want.pwm_enabled, got.pwm_enabled);
    compare_field("period_value", want.period_value, got.period_value);
    compare_field("pulse_value", want.pulse_value, got.pulse_value);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      echo_queue.delete();
      line_len = 0;
      pwm_on = 1'b0;
      period_ms = RST_PERIOD;
      pulse_ms = RST_PULSE;
      min_period_cfg = RST_MIN_PERIOD;
      max_period_cfg = RST_MAX_PERIOD;
      min_pulse_cfg = RST_MIN_PULSE;
      mismatches = 0;
    end else begin
      if (cfg.valid === 1'b1 && cfg.ready === 1'b1) begin
        case (cfg.index)
          REG_MIN_PERIOD: min_period_cfg = cfg.data;
          REG_MAX_PERIOD: max_period_cfg = cfg.data;
          REG_MIN_PULSE:  min_pulse_cfg = cfg.data;
          default: ;
        endcase
      end
      if (rx.valid === 1'b1 && rx.ready === 1'b1)
        predict_line_echo(rx.rx_byte);
      if (tx.valid === 1'b1 && tx.ready === 1'b1)
        check_echo('{tx_byte: tx.tx_byte, echo_last: tx.echo_last,
                     command_kind: kind_t'(tx.command_kind), pwm_enabled: tx.pwm_enabled,
                     period_value: tx.period_value, pulse_value: tx.pulse_value});
    end
    pending = echo_queue.size();
  end

endmodule

>>> tb/serial_command_line_parser_tb.sv
`timescale 1ns / 100ps

module serial_command_line_parser_tb;
  import scp_pkg::*;

  localparam int RESET_CYCLES  = 11;
  localparam int PHASES        = 8;
  localparam int PHASE_BYTES   = 35;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   mismatches;
  int   pending;
  int   cycles = 0;
  int   sent = 0;
  logic rx_quiet = 1'b0;
  logic tx_quiet = 1'b0;

  logic [BYTE_W-1:0] cmd_line[$];

  scp_rx_if  rx_ch();
  scp_tx_if  tx_ch();
  scp_cfg_if cfg_ch();

  serial_command_line_parser u_dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .tx  (tx_ch),
    .cfg (cfg_ch)
  );

  serial_command_line_parser_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx_ch),
    .tx         (tx_ch),
    .cfg        (cfg_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // random gap per item, with occasional runs of back-to-back traffic
  task automatic draw_wait(inout logic quiet, output int gap);
    if ($urandom_range(0, 31) == 0)
      quiet = ~quiet;
    gap = quiet ? 0 : $urandom_range(0, 7);
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    draw_wait(rx_quiet, gap);
    @(negedge clk);
    if (gap != 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (rx_ch.ready !== 1'b1);
    sent++;
  endtask

  task automatic send_line();
    foreach (cmd_line[i])
      send_byte(cmd_line[i]);
    send_byte(CHR_CR);
  endtask

  task automatic send_text(input string text);
    cmd_line.delete();
    for (int i = 0; i < text.len(); i++)
      cmd_line.push_back(text[i]);
    send_line();
  endtask

  // mostly well-formed commands, some truncated, some noise
  task automatic build_command_line();
    logic numeric;
    int   pick;
    cmd_line.delete();
    numeric = 1'b0;
    pick = $urandom_range(0, 9);
    case (pick)
      0: cmd_line = '{CHR_O, CHR_N};
      1: cmd_line = '{CHR_O, CHR_F_LC, CHR_F_LC};
      2, 3: begin
        cmd_line = '{CHR_T};
        numeric = 1'b1;
      end
      4, 5: begin
        cmd_line = '{CHR_F};
        numeric = 1'b1;
      end
      6: begin
        cmd_line = '{CHR_O};
        if ($urandom_range(0, 1) == 1)
          cmd_line.push_back(CHR_F_LC);
      end
      7: ;
      default: repeat ($urandom_range(1, 7)) cmd_line.push_back(8'($urandom_range(0, 255)));
    endcase
    if (numeric) begin
      if ($urandom_range(0, 3) == 0)
        cmd_line.push_back($urandom_range(0, 4) == 0 ? CHR_SPACE
                                                     : CHR_HT + 8'($urandom_range(0, 3)));
      case ($urandom_range(0, 3))
        0: cmd_line.push_back(CHR_PLUS);
        1: cmd_line.push_back(CHR_MINUS);
        default: ;
      endcase
      repeat ($urandom_range(0, 4)) cmd_line.push_back(CHR_0 + 8'($urandom_range(0, 9)));
    end
    if (pick <= 6 && $urandom_range(0, 3) == 0)
      cmd_line.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic await_idle();
    @(negedge clk);
    rx_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
  endtask

  task automatic write_settings(input int phase);
    logic [DATA_W-1:0] lo, hi, pmin;
    case (phase % 6)
      0: begin lo = 14'd0;    hi = 14'd9999; pmin = 14'd0;    end
      1: begin lo = 14'd9999; hi = 14'd9999; pmin = 14'd9999; end
      2: begin lo = 14'd5000; hi = 14'd100;  pmin = 14'd50;   end
      3: begin lo = 14'd0;    hi = 14'd0;    pmin = 14'd0;    end
      4: begin lo = RST_MIN_PERIOD; hi = RST_MAX_PERIOD; pmin = RST_MIN_PULSE; end
      default: begin
        lo   = DATA_W'($urandom_range(0, 9999));
        hi   = DATA_W'($urandom_range(0, 9999));
        pmin = DATA_W'($urandom_range(0, 9999));
      end
    endcase
    write_reg(REG_MIN_PERIOD, lo);
    write_reg(REG_MAX_PERIOD, hi);
    write_reg(REG_MIN_PULSE, pmin);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin : tx_drain
    int stall;
    tx_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      draw_wait(tx_quiet, stall);
      if (stall != 0) begin
        tx_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      tx_ch.ready <= 1'b1;
      do @(posedge clk); while (tx_ch.valid !== 1'b1);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int target;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = REG_MIN_PERIOD;
    cfg_ch.data   = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_text("");
    send_text("on");
    send_text("off");
    send_text("T9999");
    send_text("F\t-7");
    cmd_line = '{8'h00, 8'hFF, 8'h78, 8'h79, 8'h7A, 8'h77};
    send_line();

    for (int phase = 0; phase < PHASES; phase++) begin
      await_idle();
      write_settings(phase);
      target = sent + PHASE_BYTES;
      while (sent < target) begin
        build_command_line();
        send_line();
      end
    end

    await_idle();
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> files.f
design/scp_pkg.sv
design/scp_if.sv
design/scp_ctrl.sv
design/scp_dpath.sv
design/serial_command_line_parser.sv
tb/serial_command_line_parser_checker.sv
tb/serial_command_line_parser_tb.sv
